>>> rtl/pse_pkg.sv
// shared constants, types and state encoding of the prime sieve engine
`default_nettype none

package pse_pkg;

	// fixed field widths
	localparam int LIMIT_W   = 15;
	localparam int PRIME_W   = 14;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 16;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// defaults and reset values
	localparam int              MAX_LIMIT_DEF   = 16384;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 15'd16384;
	localparam int              FIRST_CANDIDATE = 2;

	// register index decoded from paddr[2]
	localparam logic REG_SIEVE_LIMIT = 1'b0;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_MARK,
		ST_DONE
	} state_t;

	// result of one item
	typedef struct packed {
		logic [PRIME_W-1:0] prime_value;
		logic               exhausted;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/pse_ram.sv
// generic single-port synchronous ram with registered read
`default_nettype none

module pse_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one access per cycle, read data valid the cycle after
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/pse_core.sv
// sieve sequencer: clears, scans and marks the composite bitmap in one ram
`default_nettype none

module pse_core #(
	parameter int MAX_LIMIT = pse_pkg::MAX_LIMIT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [$clog2(MAX_LIMIT+1)-1:0]    lim,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire logic                              req_restart,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output pse_pkg::result_t                       res
);

	localparam int AW = $clog2(MAX_LIMIT);
	localparam int PW = $clog2(MAX_LIMIT + 1);

	pse_pkg::state_t state_q, state_d;

	logic [PW-1:0]  pos_q;
	logic [PW-1:0]  rd_q;
	logic [PW-1:0]  hwm_q;
	logic [AW-1:0]  clr_q;
	logic           chk_v_s1;
	logic [AW-1:0]  chk_pos_s1;
	logic [AW-1:0]  p_q;
	logic [PW:0]    m_q;
	logic [pse_pkg::PRIME_W-1:0] res_prime_q;
	logic           res_exh_q;

	logic           ram_en;
	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [0:0]     ram_wdata;
	logic [0:0]     ram_rdata;

	logic           hit;
	logic           issue;
	logic           clr_last;
	logic           mark_go;

	pse_ram #(
		.WIDTH (1),
		.DEPTH (MAX_LIMIT)
	) u_marks (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// scan and mark conditions
	assign hit      = chk_v_s1 && (ram_rdata[0] == 1'b0);
	assign issue    = rd_q < lim;
	assign clr_last = (PW'(clr_q) + PW'(1)) == hwm_q;
	assign mark_go  = m_q < (PW+1)'(lim);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram control
	always_comb begin
		state_d   = state_q;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = 1'b0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			pse_pkg::ST_INIT, pse_pkg::ST_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (clr_last) begin
					state_d = (state_q == pse_pkg::ST_INIT) ? pse_pkg::ST_IDLE
						: pse_pkg::ST_SCAN;
				end
			end
			pse_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_restart && (hwm_q != '0)) begin
						state_d = pse_pkg::ST_CLEAR;
					end else begin
						state_d = pse_pkg::ST_SCAN;
					end
				end
			end
			pse_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = pse_pkg::ST_MARK;
				end else if (issue) begin
					ram_en   = 1'b1;
					ram_addr = rd_q[AW-1:0];
				end else begin
					state_d = pse_pkg::ST_DONE;
				end
			end
			pse_pkg::ST_MARK: begin
				if (mark_go) begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_addr  = m_q[AW-1:0];
					ram_wdata = 1'b1;
				end else begin
					state_d = pse_pkg::ST_DONE;
				end
			end
			pse_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = pse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pse_pkg::ST_INIT;
			end
		endcase
	end

	// control registers: scan position, read pointer, clear pointer, high-water mark, check valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= PW'(pse_pkg::FIRST_CANDIDATE);
			rd_q     <= PW'(pse_pkg::FIRST_CANDIDATE);
			hwm_q    <= PW'(MAX_LIMIT);
			clr_q    <= '0;
			chk_v_s1 <= 1'b0;
		end else begin
			case (state_q)
				pse_pkg::ST_INIT, pse_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_last) begin
						hwm_q <= '0;
						clr_q <= '0;
					end
				end
				pse_pkg::ST_IDLE: begin
					chk_v_s1 <= 1'b0;
					clr_q    <= '0;
					if (req_valid) begin
						if (req_restart) begin
							pos_q <= PW'(pse_pkg::FIRST_CANDIDATE);
							rd_q  <= PW'(pse_pkg::FIRST_CANDIDATE);
						end else begin
							rd_q <= pos_q;
						end
					end
				end
				pse_pkg::ST_SCAN: begin
					chk_v_s1 <= issue && !hit;
					if (hit) begin
						pos_q <= PW'(chk_pos_s1) + PW'(1);
						if (lim > hwm_q) begin
							hwm_q <= lim;
						end
					end else if (issue) begin
						rd_q <= rd_q + PW'(1);
					end else begin
						pos_q <= rd_q;
					end
				end
				default: begin
					chk_v_s1 <= 1'b0;
				end
			endcase
		end
	end

	// payload registers: candidate under check, prime, multiple, result
	always_ff @(posedge clk) begin
		if (state_q == pse_pkg::ST_SCAN) begin
			chk_pos_s1 <= rd_q[AW-1:0];
			if (hit) begin
				p_q         <= chk_pos_s1;
				m_q         <= (PW+1)'({chk_pos_s1, 1'b0});
				res_prime_q <= pse_pkg::PRIME_W'(chk_pos_s1);
				res_exh_q   <= 1'b0;
			end else if (!issue) begin
				res_prime_q <= '0;
				res_exh_q   <= 1'b1;
			end
		end
		if ((state_q == pse_pkg::ST_MARK) && mark_go) begin
			m_q <= m_q + (PW+1)'(p_q);
		end
	end

	assign res.prime_value = res_prime_q;
	assign res.exhausted   = res_exh_q;

`ifndef SYNTHESIS
	// reads of the bitmap only happen below the limit
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_en && !ram_we) |-> (PW'(ram_addr) < lim))
		else $error("bitmap read at or above the limit");

	// the bitmap is written only by clear passes and marking
	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_en && ram_we) |-> (state_q == pse_pkg::ST_INIT
			|| state_q == pse_pkg::ST_CLEAR || state_q == pse_pkg::ST_MARK))
		else $error("bitmap written outside clear or mark");

	// marking never touches the prime itself
	a_mark_above_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pse_pkg::ST_MARK && mark_go) |-> (m_q >= (PW+1)'({p_q, 1'b0})))
		else $error("mark below twice the prime");

	// a found prime moves the scan position just past it
	a_pos_past_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pse_pkg::ST_SCAN && hit) |=> (pos_q == PW'(p_q) + PW'(1)))
		else $error("scan position not advanced past the prime");

	// a marking write stays within the high-water mark used by the clear pass
	a_hwm_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pse_pkg::ST_MARK && mark_go) |-> ((PW+1)'(hwm_q) > m_q))
		else $error("mark above the clear high-water mark");
`endif

endmodule

`default_nettype wire

>>> rtl/prime_sieve_engine_top.sv
// prime sieve engine top level: config register, stream ports and output register
//
//   channel   | dir | fields (lsb first)                         | handshake
//   s_axis    | in  | tdata[0] restart                           | tvalid/tready
//   m_axis    | out | tdata[13:0] prime_value, tuser exhausted   | tvalid/tready
//   apb       | in  | pwdata[14:0] sieve_limit at byte addr 0    | psel/penable, pready=1
//
// after reset a clear pass over the whole bitmap runs with s_axis_tready low
// an item is accepted, scans the candidates until an unmarked one or the limit,
//   marks the multiples of a found prime with about limit/prime writes, then hands over
// a restart item adds a clear pass of up to the highest limit marked since the last clear
// the single bitmap ram port takes one read or write per cycle
// one item is in work at a time; the output register lets the next item in while a result waits
`default_nettype none

module prime_sieve_engine_top #(
	parameter int MAX_LIMIT = pse_pkg::MAX_LIMIT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input stream; tdata: [0] restart
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [pse_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// output stream; tdata: [13:0] prime_value; tuser: [0] exhausted
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [pse_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	output logic                               m_axis_tuser,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pse_pkg::APB_AW-1:0]    paddr,
	input  wire logic [pse_pkg::APB_DW-1:0]    pwdata,
	output logic [pse_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);

	localparam int PW = $clog2(MAX_LIMIT + 1);
	localparam int CW = (PW > pse_pkg::LIMIT_W) ? PW : pse_pkg::LIMIT_W;

	logic [pse_pkg::LIMIT_W-1:0] limit_q;
	logic [PW-1:0]               lim;
	logic                        cfg_wr;
	logic                        res_valid;
	logic                        res_ready;
	pse_pkg::result_t            res;
	logic                        out_v_q;
	pse_pkg::result_t            out_q;

	// config register write and read
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[pse_pkg::APB_AW-1] == pse_pkg::REG_SIEVE_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pse_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[pse_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[pse_pkg::APB_AW-1] == pse_pkg::REG_SIEVE_LIMIT) begin
			prdata = pse_pkg::APB_DW'(limit_q);
		end
	end

	// effective limit saturated to the bitmap depth
	assign lim = (CW'(limit_q) > CW'(MAX_LIMIT)) ? PW'(MAX_LIMIT) : PW'(limit_q);

	pse_core #(
		.MAX_LIMIT (MAX_LIMIT)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.lim         (lim),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req_restart (s_axis_tdata[0]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// output register
	assign res_ready = !out_v_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = pse_pkg::M_TDATA_W'(out_q.prime_value);
	assign m_axis_tuser  = out_q.exhausted;

endmodule

`default_nettype wire

>>> verif/tb_prime_sieve_engine_top.sv
// testbench of the prime sieve engine: sieve scoreboard, stream and register drivers
module tb_prime_sieve_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pse_pkg::*;

	localparam int unsigned RUN_ITEMS      = 580;
	localparam int unsigned TAIL_START     = 520;
	localparam int unsigned PRESSURE_PHASE = 3;
	localparam int unsigned HOLD_CYCLES    = 20000;
	localparam int unsigned REPORT_MAX     = 10;
	localparam logic [APB_AW-1:0] SIEVE_LIMIT_ADDR = {REG_SIEVE_LIMIT, 2'b00};

	// sieve state mirror and queue of the primes still owed by the block
	class prime_sieve_scoreboard;
		bit                 composite[MAX_LIMIT_DEF];
		int unsigned        scan_pos;
		logic [LIMIT_W-1:0] limit_reg;
		result_t            owed_primes[$];
		int unsigned        errors;

		function new();
			foreach (composite[k])
				composite[k] = 1'b0;
			scan_pos  = FIRST_CANDIDATE;
			limit_reg = LIMIT_RESET;
			errors    = 0;
		endfunction

		function void report(string what);
			errors++;
			if (errors <= REPORT_MAX)
				$display("error at %0t: %s", $realtime, what);
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] lim);
			limit_reg = lim;
		endfunction

		function int unsigned pending();
			return owed_primes.size();
		endfunction

		// one sieve step for an accepted item
		function void note_request(bit restart);
			int unsigned lim;
			int unsigned pos;
			int unsigned m;
			result_t     r;
			lim = limit_reg;
			if (lim > MAX_LIMIT_DEF)
				lim = MAX_LIMIT_DEF;
			if (restart) begin
				foreach (composite[k])
					composite[k] = 1'b0;
				scan_pos = FIRST_CANDIDATE;
			end
			pos = scan_pos;
			while (pos < lim && composite[pos])
				pos++;
			if (pos >= lim) begin
				scan_pos      = pos;
				r.prime_value = '0;
				r.exhausted   = 1'b1;
			end else begin
				for (m = pos + pos; m < lim; m += pos)
					composite[m] = 1'b1;
				scan_pos      = pos + 1;
				r.prime_value = PRIME_W'(pos);
				r.exhausted   = 1'b0;
			end
			owed_primes.push_back(r);
		endfunction

		// compare one delivered item with the oldest owed one
		function void check_result(logic [PRIME_W-1:0] prime, logic exh);
			result_t want;
			if (owed_primes.size() == 0) begin
				report($sformatf("unexpected result prime %0d exhausted %0b", prime, exh));
				return;
			end
			want = owed_primes.pop_front();
			if (prime !== want.prime_value || exh !== want.exhausted)
				report($sformatf("expected prime %0d exhausted %0b, got prime %0d exhausted %0b",
					want.prime_value, want.exhausted, prime, exh));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	prime_sieve_scoreboard sb;
	bit                    idle_on;
	bit                    pressure_armed;
	bit                    pressure_done;
	int unsigned           items_sent;

	prime_sieve_engine_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// 100 MHz clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// offer one request item and wait until it is taken
	task automatic send_request(input bit restart);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, restart};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(restart);
		items_sent++;
	endtask

	// stop offering and wait for every owed result
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// bus back to idle before the next transfer
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_limit_reg(input logic [LIMIT_W-1:0] lim);
		logic [APB_DW-1:0] rd;
		apb_read(SIEVE_LIMIT_ADDR, rd);
		if (rd[LIMIT_W-1:0] !== lim)
			sb.report($sformatf("sieve_limit reads %0d, expected %0d", rd[LIMIT_W-1:0], lim));
	endtask

	// new limit once the block is idle, then read it back
	task automatic program_limit(input logic [LIMIT_W-1:0] lim);
		settle();
		apb_write(SIEVE_LIMIT_ADDR, APB_DW'(lim));
		sb.set_limit(lim);
		check_limit_reg(lim);
	endtask

	// result side: random stalls, one long hold-off, checks
	initial begin : result_sink
		int unsigned stall_left;
		m_axis_tready <= 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata[PRIME_W-1:0], m_axis_tuser);
			if (pressure_armed && !pressure_done) begin
				pressure_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 16);
			end
		end
	end

	// main sequence
	initial begin : stimulus
		int unsigned phase_no;
		int unsigned lim;
		int unsigned count;
		bit          restart;
		sb             = new();
		idle_on        = 1'b1;
		pressure_armed = 1'b0;
		pressure_done  = 1'b0;
		items_sent     = 0;
		phase_no       = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset limit: continue from reset state, then restart
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);
		settle();
		check_limit_reg(LIMIT_RESET);
		// limits 0 to 2 report exhausted, limit 3 still yields the prime 2
		program_limit(15'd0);
		send_request(1'b0);
		send_request(1'b1);
		program_limit(15'd1);
		send_request(1'b0);
		program_limit(15'd2);
		send_request(1'b1);
		program_limit(15'd3);
		send_request(1'b0);
		// limit above the bitmap size saturates
		program_limit(15'h7FFF);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		program_limit(15'd16384);
		send_request(1'b0);
		// shrink without restart, run past the end, then grow again
		program_limit(15'd20);
		repeat (6) send_request(1'b0);
		program_limit(15'd40);
		repeat (2) send_request(1'b0);

		// random phases, each under its own limit
		while (items_sent < RUN_ITEMS) begin
			phase_no++;
			if (phase_no == PRESSURE_PHASE) begin
				lim   = 200;
				count = 30;
			end else if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						lim = 16384;
					end
					1: begin
						lim = $urandom_range(16385, 32767);
					end
					default: begin
						lim = $urandom_range(1024, 16383);
					end
				endcase
				count = $urandom_range(10, 25);
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						lim = $urandom_range(0, 3);
					end
					1, 2: begin
						lim = $urandom_range(4, 40);
					end
					default: begin
						lim = $urandom_range(41, 700);
					end
				endcase
				count = $urandom_range(8, 40);
			end
			program_limit(LIMIT_W'(lim));
			idle_on = (items_sent < TAIL_START) && (phase_no != PRESSURE_PHASE) &&
				($urandom_range(0, 3) != 0);
			if (phase_no == PRESSURE_PHASE)
				pressure_armed = 1'b1;
			for (int unsigned i = 0; i < count; i++) begin
				if (i == 0)
					restart = (phase_no == PRESSURE_PHASE) || ($urandom_range(0, 2) != 0);
				else
					restart = ($urandom_range(0, 15) == 0);
				send_request(restart);
			end
		end

		settle();
		repeat (MAX_LIMIT_DEF) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("prime_sieve_engine_top: match");
		else
			$display("prime_sieve_engine_top: mismatch");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#100_000_000;
		$display("prime_sieve_engine_top: mismatch");
		$finish;
	end

endmodule
